// ===== design/pfi_pkg.sv =====
// shared widths, request codes and saturation helpers for the particle integrator
package pfi_pkg;

    // operand and product widths of the serial units
    localparam int MAG_W = 32;
    localparam int SQ_W  = 64;

    // request codes
    typedef enum logic [1:0] {
        REQ_REPEL   = 2'd0,
        REQ_ATTRACT = 2'd1,
        REQ_GLOBAL  = 2'd2,
        REQ_TICK    = 2'd3
    } t_req;

    // sign extend to the sum width
    function automatic logic signed [33:0] sx34(input logic signed [31:0] a);
        return {{2{a[31]}}, a};
    endfunction

    // clip a 34 bit sum to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            res = v[31:0];
        end else if (v[33]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // magnitude of a signed word, the most negative value gives 2^31
    function automatic logic [MAG_W-1:0] mag32(input logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    // apply a sign to a magnitude
    function automatic logic signed [31:0] signed32(input logic [31:0] m, input logic neg);
        return neg ? (~m + 32'd1) : m;
    endfunction

endpackage

// ===== design/particle_force_integrator_top.sv =====
// particle force integrator: request sequencer, particle state and output register
// serial units: the multiplier takes 32 iterations, the square root 32 and the divider
//   32 + FRAC_BITS iterations per pass
// throughput: one request in flight; the next request is taken while the last result waits
// reset: synchronous, active low; particle state clears to zero, damping returns to 64881
module particle_force_integrator_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic [30:0]        i_radius,
    input  logic signed [31:0] i_strength,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import pfi_pkg::*;

    localparam int          NW        = MAG_W + FRAC_BITS;
    localparam logic [31:0] ONE       = 32'd1 << FRAC_BITS;
    localparam logic [31:0] LOW       = 32'((3 * (1 << FRAC_BITS)) / 10);
    localparam logic [31:0] ONE_M_LOW = ONE - LOW;
    localparam logic [31:0] GLOBAL_R  = 32'd1000;

    typedef enum logic [3:0] {
        S_IDLE, S_TPOS, S_TDAMP, S_DIFF, S_SQX, S_SQY, S_RSQ,
        S_ROOT, S_PCT, S_NORM, S_F1, S_F2, S_FIN
    } t_state;

    t_state              r_state;
    logic                r_wait;
    logic                r_axis;
    logic                r_mouse;
    t_req                r_req;
    logic signed [31:0]  r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic signed [31:0]  r_acc_x, r_acc_y, r_mdir_x, r_mdir_y;
    logic [15:0]         r_damping;
    logic signed [31:0]  r_px, r_py;
    logic [30:0]         r_radius;
    logic [31:0]         r_mag_s;
    logic                r_neg_s;
    logic [31:0]         r_mag_x, r_mag_y;
    logic                r_neg_x, r_neg_y;
    logic [SQ_W-1:0]     r_sq, r_rsq;
    logic [31:0]         r_len;
    logic [31:0]         r_pct;
    logic [31:0]         r_t;
    logic                r_out_valid;
    logic signed [31:0]  r_out_px, r_out_py, r_out_vx, r_out_vy;

    logic                mul_start, mul_done;
    logic [MAG_W-1:0]    mul_a, mul_b;
    logic [SQ_W-1:0]     mul_prod;
    logic                sqrt_start, sqrt_done;
    logic [MAG_W-1:0]    sqrt_root;
    logic                div_start, div_done;
    logic [NW-1:0]       div_num;
    logic [MAG_W-1:0]    div_den;
    logic [NW-1:0]       div_quot;

    logic [31:0]         n_mag_axis;
    logic                n_neg_axis;
    logic signed [31:0]  n_vel_axis;
    logic signed [31:0]  n_acc_axis;
    logic signed [31:0]  n_dx, n_dy;
    logic [31:0]         n_damped;
    logic [31:0]         n_force;
    logic                n_sub;
    logic signed [33:0]  n_delta;
    logic signed [31:0]  n_acc_new;

    // per axis selections
    always_comb begin
        n_mag_axis = r_axis ? r_mag_y : r_mag_x;
        n_neg_axis = r_axis ? r_neg_y : r_neg_x;
        n_vel_axis = r_axis ? r_vel_y : r_vel_x;
        n_acc_axis = r_axis ? r_acc_y : r_acc_x;
        n_dx       = sat32(sx34(r_pos_x) - sx34(r_px));
        n_dy       = sat32(sx34(r_pos_y) - sx34(r_py));
        n_damped   = mul_prod[16 +: 32];
        n_force    = mul_prod[FRAC_BITS +: 32];
        n_sub      = n_neg_axis ^ r_neg_s ^ (r_req != REQ_REPEL);
        n_delta    = n_sub ? -$signed({2'b00, n_force}) : $signed({2'b00, n_force});
        n_acc_new  = sat32(sx34(n_acc_axis) + n_delta);
    end

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = r_mag_x;
                mul_b = r_mag_x;
            end
            S_SQY: begin
                mul_a = r_mag_y;
                mul_b = r_mag_y;
            end
            S_RSQ: begin
                mul_a = {1'b0, r_radius};
                mul_b = {1'b0, r_radius};
            end
            S_TDAMP: begin
                mul_a = mag32(n_vel_axis);
                mul_b = {16'd0, r_damping};
            end
            S_F1: begin
                mul_a = r_t;
                mul_b = r_pct;
            end
            S_F2: begin
                mul_a = r_t;
                mul_b = r_mag_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands
    always_comb begin
        if (r_state == S_PCT) begin
            if (r_req == REQ_GLOBAL) begin
                div_num = NW'(r_len);
                div_den = GLOBAL_R;
            end else begin
                div_num = {r_len, {FRAC_BITS{1'b0}}};
                div_den = {1'b0, r_radius};
            end
        end else begin
            div_num = {n_mag_axis, {FRAC_BITS{1'b0}}};
            div_den = r_len;
        end
    end

    // unit launches
    assign mul_start  = !r_wait && (r_state == S_SQX || r_state == S_SQY ||
                        r_state == S_RSQ || r_state == S_TDAMP ||
                        r_state == S_F1 || r_state == S_F2);
    assign sqrt_start = !r_wait && (r_state == S_ROOT);
    assign div_start  = !r_wait && (r_state == S_PCT || (r_state == S_NORM && r_len != '0));

    pfi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pfi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    pfi_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer, particle state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_axis      <= 1'b0;
            r_mouse     <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_mdir_x    <= '0;
            r_mdir_y    <= '0;
            r_damping   <= 16'd64881;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_damping <= i_cfg_wdata;
            end
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req      <= t_req'(i_req_type);
                        r_px       <= i_point_x;
                        r_py       <= i_point_y;
                        r_radius   <= i_radius;
                        r_mag_s    <= mag32(i_strength);
                        r_neg_s    <= i_strength[31];
                        r_wait     <= 1'b0;
                        if (t_req'(i_req_type) == REQ_TICK) begin
                            r_mdir_x <= i_point_x;
                            r_mdir_y <= i_point_y;
                            r_state  <= S_TPOS;
                        end else begin
                            r_state  <= S_DIFF;
                        end
                    end
                end
                S_TPOS: begin
                    r_pos_x <= sat32(sx34(r_pos_x) + sx34(r_vel_x));
                    r_pos_y <= sat32(sx34(r_pos_y) + sx34(r_vel_y));
                    r_vel_x <= sat32(sx34(r_vel_x) + sx34(r_acc_x));
                    r_vel_y <= sat32(sx34(r_vel_y) + sx34(r_acc_y));
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_axis  <= 1'b0;
                    r_state <= S_TDAMP;
                end
                S_TDAMP: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_axis) begin
                            r_vel_y <= signed32(n_damped, r_vel_y[31]);
                            r_state <= S_FIN;
                        end else begin
                            r_vel_x <= signed32(n_damped, r_vel_x[31]);
                            r_axis  <= 1'b1;
                        end
                    end
                end
                S_DIFF: begin
                    r_mag_x <= mag32(n_dx);
                    r_neg_x <= n_dx[31];
                    r_mag_y <= mag32(n_dy);
                    r_neg_y <= n_dy[31];
                    r_mouse <= 1'b0;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_sq    <= mul_prod;
                        r_state <= S_SQY;
                    end
                end
                S_SQY: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        r_sq   <= r_sq + mul_prod;
                        if (r_mouse || r_req == REQ_GLOBAL) begin
                            r_state <= S_ROOT;
                        end else begin
                            r_state <= S_RSQ;
                        end
                    end
                end
                S_RSQ: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_rsq   <= mul_prod;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (sqrt_done) begin
                        r_wait <= 1'b0;
                        r_len  <= sqrt_root;
                        r_axis <= 1'b0;
                        priority if (r_mouse) begin
                            r_state <= S_NORM;
                        end else if (r_req == REQ_GLOBAL || r_sq < r_rsq) begin
                            r_state <= S_PCT;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_PCT: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait <= 1'b0;
                        unique case (r_req)
                            REQ_REPEL: r_pct <= div_quot[31:0];
                            REQ_ATTRACT: r_pct <= ONE - div_quot[31:0];
                            default: begin
                                // clamp the falloff at its lower bound
                                if (div_quot > NW'(ONE_M_LOW)) begin
                                    r_pct <= LOW;
                                end else begin
                                    r_pct <= ONE - div_quot[31:0];
                                end
                            end
                        endcase
                        if (r_req == REQ_REPEL) begin
                            r_mag_x <= mag32(r_mdir_x);
                            r_neg_x <= r_mdir_x[31];
                            r_mag_y <= mag32(r_mdir_y);
                            r_neg_y <= r_mdir_y[31];
                            r_mouse <= 1'b1;
                            r_state <= S_SQX;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // a zero length vector gives no force
                    if (r_len == '0) begin
                        r_state <= S_FIN;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= div_quot[31:0];
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= n_force;
                        r_state <= S_F2;
                    end
                end
                S_F2: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_axis) begin
                            r_acc_y <= n_acc_new;
                            r_state <= S_FIN;
                        end else begin
                            r_acc_x <= n_acc_new;
                            r_axis  <= 1'b1;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_px    <= r_pos_x;
                        r_out_py    <= r_pos_y;
                        r_out_vx    <= r_vel_x;
                        r_out_vy    <= r_vel_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_position_x = r_out_px;
    assign o_position_y = r_out_py;
    assign o_velocity_x = r_out_vx;
    assign o_velocity_y = r_out_vy;

    // no unit is left running while the sequencer waits for a request
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wait)
        else $error("unit wait flag set while idle");

    // a tick clears acceleration before damping starts
    a_tick_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TPOS) |=> (r_acc_x == '0 && r_acc_y == '0))
        else $error("acceleration not cleared on tick");

    // a waiting result is never overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_stall) |=> (r_state == S_FIN))
        else $error("result overwritten while stalled");

    // falloff weight never exceeds one
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F1) |-> (r_pct <= ONE))
        else $error("falloff weight out of range");

endmodule

// ===== design/pfi_mul.sv =====
// shift and add multiplier, one multiplier bit per cycle
module pfi_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfi_pkg::MAG_W-1:0]   i_a,
    input  logic [pfi_pkg::MAG_W-1:0]   i_b,
    output logic                        o_done,
    output logic [pfi_pkg::SQ_W-1:0]    o_prod
);
    import pfi_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic [MAG_W-1:0]    r_a;
    logic [SQ_W-1:0]     r_prod;
    logic [MAG_W:0]      n_sum;
    logic [SQ_W-1:0]     n_prod;

    // add the multiplicand into the upper half when the low bit is set, then shift
    always_comb begin
        n_sum  = {1'b0, r_prod[SQ_W-1:MAG_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
        n_prod = {n_sum, r_prod[MAG_W-1:1]};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{MAG_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== design/pfi_sqrt.sv =====
// floor square root, two radicand bits per cycle
module pfi_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfi_pkg::SQ_W-1:0]    i_rad,
    output logic                        o_done,
    output logic [pfi_pkg::MAG_W-1:0]   o_root
);
    import pfi_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [SQ_W-1:0]    r_rad;
    logic [MAG_W:0]     r_rem;
    logic [MAG_W-1:0]   r_root;
    logic [MAG_W+2:0]   n_cat;
    logic [MAG_W+2:0]   n_trial;
    logic               n_ge;
    logic [MAG_W+2:0]   n_diff;

    // one restoring step
    always_comb begin
        n_cat   = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = (n_cat >= n_trial);
        n_diff  = n_cat - n_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= n_ge ? n_diff[MAG_W:0] : n_cat[MAG_W:0];
            r_root <= {r_root[MAG_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/pfi_div.sv =====
// restoring divider, one quotient bit per cycle
module pfi_div #(
    parameter int NW = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NW-1:0]               i_num,
    input  logic [pfi_pkg::MAG_W-1:0]   i_den,
    output logic                        o_done,
    output logic [NW-1:0]               o_quot
);
    import pfi_pkg::*;

    localparam int CW = $clog2(NW);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [NW-1:0]      r_q;
    logic [MAG_W-1:0]   r_rem;
    logic [MAG_W-1:0]   r_den;
    logic [MAG_W:0]     n_cat;
    logic               n_ge;
    logic [MAG_W:0]     n_diff;

    // shift in the next numerator bit and try the subtract
    always_comb begin
        n_cat  = {r_rem, r_q[NW-1]};
        n_ge   = (n_cat >= {1'b0, r_den});
        n_diff = n_cat - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[MAG_W-1:0] : n_cat[MAG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== dv/particle_force_integrator_checker.sv =====
// request and result monitor with a particle state predictor for the force integrator
`timescale 1ns / 100ps
module particle_force_integrator_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic [30:0]        i_radius,
    input  logic signed [31:0] i_strength,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_velocity_x,
    input  logic signed [31:0] i_velocity_y,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pfi_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_particle;

    // predicted particle state
    longint m_pos_x, m_pos_y, m_vel_x, m_vel_y, m_acc_x, m_acc_y, m_dir_x, m_dir_y;
    longint unsigned m_damping;
    t_particle expected_states[$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint with_sign(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return with_sign((abs64(a) * abs64(b)) >> FRAC, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(input longint a, input longint unsigned den);
        return with_sign((abs64(a) << FRAC) / den, a < 0);
    endfunction

    function automatic longint unsigned sq_len(input longint x, input longint y);
        return abs64(x) * abs64(x) + abs64(y) * abs64(y);
    endfunction

    // advance the particle by one request
    task automatic integrate_request(input t_req req, input longint px, input longint py,
                                     input longint unsigned rad, input longint str);
        longint dx, dy, nx, ny, pct, lowc;
        longint unsigned sq, len, msq, mlen;
        bit act;
        if (req == REQ_TICK) begin
            m_pos_x = clip32(m_pos_x + m_vel_x);
            m_pos_y = clip32(m_pos_y + m_vel_y);
            m_vel_x = clip32(m_vel_x + m_acc_x);
            m_vel_y = clip32(m_vel_y + m_acc_y);
            m_vel_x = with_sign((abs64(m_vel_x) * m_damping) >> 16, m_vel_x < 0);
            m_vel_y = with_sign((abs64(m_vel_y) * m_damping) >> 16, m_vel_y < 0);
            m_acc_x = 0;
            m_acc_y = 0;
            m_dir_x = px;
            m_dir_y = py;
        end else begin
            dx = clip32(m_pos_x - px);
            dy = clip32(m_pos_y - py);
            sq = sq_len(dx, dy);
            len = floor_sqrt(sq);
            if (req == REQ_REPEL) begin
                if (sq < rad * rad) begin
                    pct = (len << FRAC) / rad;
                    msq = sq_len(m_dir_x, m_dir_y);
                    mlen = floor_sqrt(msq);
                    nx = mlen == 0 ? 0 : fx_div(m_dir_x, mlen);
                    ny = mlen == 0 ? 0 : fx_div(m_dir_y, mlen);
                    m_acc_x = clip32(m_acc_x + fx_mul(fx_mul(nx, pct), str));
                    m_acc_y = clip32(m_acc_y + fx_mul(fx_mul(ny, pct), str));
                end
            end else begin
                act = 1;
                if (req == REQ_ATTRACT) begin
                    act = sq < rad * rad;
                    pct = act ? (64'sd1 << FRAC) - longint'((len << FRAC) / rad) : 0;
                end else begin
                    lowc = (64'd3 << FRAC) / 10;
                    pct = (64'sd1 << FRAC) - longint'(len / 1000);
                    if (pct < lowc) pct = lowc;
                    if (pct > (64'sd1 << FRAC)) pct = 64'sd1 << FRAC;
                end
                if (act) begin
                    nx = len == 0 ? 0 : fx_div(dx, len);
                    ny = len == 0 ? 0 : fx_div(dy, len);
                    m_acc_x = clip32(m_acc_x - fx_mul(fx_mul(nx, pct), str));
                    m_acc_y = clip32(m_acc_y - fx_mul(fx_mul(ny, pct), str));
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    assign o_pending = expected_states.size();

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_particle want;
        if (!i_rst_n) begin
            m_pos_x = 0; m_pos_y = 0; m_vel_x = 0; m_vel_y = 0;
            m_acc_x = 0; m_acc_y = 0; m_dir_x = 0; m_dir_y = 0;
            m_damping = 64881;
            expected_states.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) m_damping = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("unexpected result", i_position_x, 32'h0);
                end else begin
                    want = expected_states.pop_front();
                    if (i_position_x !== want.px)
                        report_mismatch("position_x", i_position_x, want.px);
                    if (i_position_y !== want.py)
                        report_mismatch("position_y", i_position_y, want.py);
                    if (i_velocity_x !== want.vx)
                        report_mismatch("velocity_x", i_velocity_x, want.vx);
                    if (i_velocity_y !== want.vy)
                        report_mismatch("velocity_y", i_velocity_y, want.vy);
                end
            end
            if (i_valid && !i_in_stall) begin
                integrate_request(t_req'(i_req_type), i_point_x, i_point_y, i_radius,
                                  i_strength);
                want.px = m_pos_x[31:0];
                want.py = m_pos_y[31:0];
                want.vx = m_vel_x[31:0];
                want.vy = m_vel_y[31:0];
                expected_states.push_back(want);
            end
        end
    end

endmodule

// ===== dv/particle_force_integrator_top_tb.sv =====
// stimulus, clock, reset and verdict for the particle force integrator
`timescale 1ns / 100ps
module particle_force_integrator_top_tb;
    import pfi_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               req_valid = 0;
    logic               req_stall;
    logic [1:0]         req_type = REQ_TICK;
    logic signed [31:0] point_x = 0;
    logic signed [31:0] point_y = 0;
    logic [30:0]        radius = 0;
    logic signed [31:0] strength = 0;
    logic               res_valid;
    logic               res_stall = 0;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic               cfg_we = 0;
    logic [15:0]        cfg_wdata = 0;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_cycles = 0;

    always #5 clk = ~clk;

    particle_force_integrator_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_stall(req_stall),
        .i_req_type(req_type), .i_point_x(point_x), .i_point_y(point_y),
        .i_radius(radius), .i_strength(strength), .o_valid(res_valid),
        .i_stall(res_stall), .o_position_x(pos_x), .o_position_y(pos_y),
        .o_velocity_x(vel_x), .o_velocity_y(vel_y), .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    particle_force_integrator_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .i_in_stall(req_stall),
        .i_req_type(req_type), .i_point_x(point_x), .i_point_y(point_y),
        .i_radius(radius), .i_strength(strength), .i_out_valid(res_valid),
        .i_out_stall(res_stall), .i_position_x(pos_x), .i_position_y(pos_y),
        .i_velocity_x(vel_x), .i_velocity_y(vel_y), .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, with a long hold-off when requested
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            res_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input t_req rq, input logic [31:0] x, input logic [31:0] y,
                                input logic [30:0] r, input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        req_type  <= rq;
        point_x   <= x;
        point_y   <= y;
        radius    <= r;
        strength  <= s;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic write_damping(input logic [15:0] v);
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // scaled random coordinate: mostly near the origin, sometimes anywhere
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(20000000)) - 10000000;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'd0;
            default: return 31'($urandom_range(30000000));
        endcase
    endfunction

    function automatic logic [31:0] rand_strength();
        case ($urandom_range(2))
            0: return $urandom;
            default: return $signed($urandom_range(400000)) - 200000;
        endcase
    endfunction

    task automatic random_requests(input int count);
        t_req rq;
        for (int k = 0; k < count; k++) begin
            rq = t_req'($urandom_range(3));
            send_request(rq, rand_coord(), rand_coord(), rand_radius(), rand_strength());
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero vectors, zero radius, every request
        send_request(REQ_REPEL, 0, 0, 100, 32'h0001_0000);
        send_request(REQ_ATTRACT, 0, 0, 100, 32'h0001_0000);
        send_request(REQ_GLOBAL, 0, 0, 0, 32'h0001_0000);
        send_request(REQ_TICK, 32'h0003_0000, 32'hFFFC_0000, 0, 0);
        send_request(REQ_REPEL, 32'h0000_8000, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_ATTRACT, 32'h0010_0000, 32'h0010_0000, 31'h7FFF_FFFF,
                     32'h8000_0000);
        send_request(REQ_GLOBAL, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
        send_request(REQ_GLOBAL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000);
        send_request(REQ_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                     32'hFFFF_FFFF);
        send_request(REQ_REPEL, 32'h0000_1000, 32'h0000_1000, 0, 32'h0001_0000);
        send_request(REQ_ATTRACT, 32'h0000_1000, 32'h0000_1000, 0, 32'h0001_0000);
        send_request(REQ_GLOBAL, 32'h0100_0000, 0, 0, 32'h0100_0000);
        send_request(REQ_TICK, 0, 0, 0, 0);
        send_request(REQ_GLOBAL, 32'h0400_0000, 32'h0400_0000, 0, 32'h4000_0000);
        send_request(REQ_TICK, 32'h0001_0000, 0, 0, 0);
        send_request(REQ_REPEL, 32'h0000_0001, 0, 31'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_TICK, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, 0);

        // phase: damping at its extremes, without and then with sender idling
        write_damping(16'hFFFF);
        random_requests(250);
        write_damping(16'h0000);
        send_idle_pct = 67;
        random_requests(250);

        // phase: receiver stalls, with a long hold-off while requests keep coming
        write_damping(16'h8000);
        send_idle_pct = 0;
        stall_pct = 67;
        hold_cycles <= 3000;
        random_requests(250);

        // phase: both sides idle, then neither with the reset damping
        write_damping(16'($urandom));
        send_idle_pct = 14;
        stall_pct = 14;
        random_requests(250);
        send_idle_pct = 0;
        stall_pct = 0;
        write_damping(16'd64881);
        random_requests(230);

        req_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/pfi_pkg.sv
design/pfi_mul.sv
design/pfi_sqrt.sv
design/pfi_div.sv
design/particle_force_integrator_top.sv
dv/particle_force_integrator_checker.sv
dv/particle_force_integrator_top_tb.sv
